// ----- hdl/sod_pkg.sv -----
`timescale 1ns / 1ps
package sod_pkg;

  typedef enum logic [1:0] {
    FUNC_DETECT = 2'd0,
    FUNC_ON     = 2'd1,
    FUNC_OFF    = 2'd2,
    FUNC_READ   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    KIND_OBSTACLE = 2'd0,
    KIND_DISTANCE = 2'd1,
    KIND_PERIOD   = 2'd2
  } kind_e;

  // configuration register indexes
  localparam logic CFG_TRIGGER_LEVEL = 1'b0;
  localparam logic CFG_INTERVAL      = 1'b1;

  localparam int          RANGE_W         = 8;
  localparam int          INTERVAL_W      = 16;
  localparam int          PERIOD_W        = 15;
  localparam logic [7:0]  RANGE_MAX       = 8'd255;
  localparam logic [15:0] MIN_INTERVAL_MS = 16'd165;

  // floor(x / 3) for 16-bit x: (x * ceil(2^17 / 3)) >> 17
  localparam int          PERIOD_SHIFT = 17;
  localparam logic [16:0] PERIOD_RECIP = 17'd43691;

endpackage

// ----- hdl/sonar_obstacle_detect_and_range.sv -----
`timescale 1ns / 1ps
// Results: a result is registered from its input transaction and is valid in the following cycle.
// Throughput: one input transaction per cycle; input is stalled only while a
// finished result is held by a stalled output.
// Reset: asynchronous, active low; detector disarmed, history and read
// accumulators cleared, notices enabled, trigger 255, interval 0.
module sonar_obstacle_detect_and_range
  import sod_pkg::*;
#(
  parameter int HITS_REQUIRED    = 3,
  parameter int READ_COUNT_TOTAL = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [INTERVAL_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            func_i,
  input  logic [RANGE_W-1:0]    range_sample_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            result_kind_o,
  output logic [RANGE_W-1:0]    distance_average_o,
  output logic [RANGE_W-1:0]    distance_maximum_o,
  output logic [RANGE_W-1:0]    distance_minimum_o,
  output logic [PERIOD_W-1:0]   sample_period_ms_o
);

  localparam int CNT_W   = $clog2(READ_COUNT_TOTAL + 1);
  localparam int SUM_W   = RANGE_W + $clog2(READ_COUNT_TOTAL + 1);
  localparam int AVG_SH  = SUM_W + 3;
  localparam int AVG_RCP = ((1 << AVG_SH) + READ_COUNT_TOTAL - 1) / READ_COUNT_TOTAL;
  localparam int PROD_W  = SUM_W + AVG_SH + 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(READ_COUNT_TOTAL);

  logic [RANGE_W-1:0]       trigger_level_q;
  logic [INTERVAL_W-1:0]    interval_q;
  logic                     armed_q, armed_d;
  logic [HITS_REQUIRED-1:0] hist_q, hist_d;
  logic                     notice_en_q, notice_en_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [SUM_W-1:0]         sum_q, sum_d;
  logic [RANGE_W-1:0]       max_q, max_d;
  logic [RANGE_W-1:0]       min_q, min_d;
  logic [RANGE_W-1:0]       trig_q, trig_d;

  logic                  out_valid_q;
  kind_e                 kind_q, kind_d;
  logic [RANGE_W-1:0]    avg_q, avg_d;
  logic [RANGE_W-1:0]    dmax_q, dmax_d;
  logic [RANGE_W-1:0]    dmin_q, dmin_d;
  logic [PERIOD_W-1:0]   period_q, period_d;
  logic                  emit;

  logic                     accept;
  func_e                    func;
  logic [HITS_REQUIRED-1:0] hist_sh;
  logic [CNT_W-1:0]         cnt_inc;
  logic [SUM_W-1:0]         sum_inc;
  logic [RANGE_W-1:0]       max_new, min_new;
  logic [INTERVAL_W-1:0]    iv_clamp;
  logic [32:0]              period_prod;
  logic [PROD_W-1:0]        avg_prod;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign func       = func_e'(func_i);

  assign hist_sh  = HITS_REQUIRED'({hist_q, (range_sample_i < trig_q)});
  assign cnt_inc  = cnt_q + 1'b1;
  assign sum_inc  = sum_q + SUM_W'(range_sample_i);
  assign max_new  = (range_sample_i > max_q) ? range_sample_i : max_q;
  assign min_new  = (range_sample_i < min_q) ? range_sample_i : min_q;
  assign iv_clamp = (interval_q < MIN_INTERVAL_MS) ? MIN_INTERVAL_MS : interval_q;

  assign period_prod = 33'(iv_clamp) * 33'(PERIOD_RECIP);
  assign avg_prod    = PROD_W'(sum_inc) * PROD_W'(AVG_RCP);

  always_comb begin
    armed_d     = armed_q;
    hist_d      = hist_q;
    notice_en_d = notice_en_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    max_d       = max_q;
    min_d       = min_q;
    trig_d      = trig_q;
    emit        = 1'b0;
    kind_d      = KIND_OBSTACLE;
    avg_d       = '0;
    dmax_d      = '0;
    dmin_d      = '0;
    period_d    = '0;
    case (func)
      FUNC_DETECT: begin
        if (armed_q) begin
          hist_d = hist_sh;
          if (notice_en_q && (&hist_sh)) begin
            // drop the newest hit and block further notices
            hist_d      = hist_sh & ~HITS_REQUIRED'(1);
            notice_en_d = 1'b0;
            emit        = 1'b1;
            kind_d      = KIND_OBSTACLE;
          end
        end
      end
      FUNC_ON: begin
        if (!armed_q) begin
          armed_d  = 1'b1;
          trig_d   = trigger_level_q;
          emit     = 1'b1;
          kind_d   = KIND_PERIOD;
          period_d = period_prod[PERIOD_SHIFT +: PERIOD_W];
        end
      end
      FUNC_OFF: begin
        armed_d     = 1'b0;
        hist_d      = '0;
        notice_en_d = 1'b1;
        cnt_d       = '0;
        sum_d       = '0;
        max_d       = '0;
        min_d       = RANGE_MAX;
        trig_d      = RANGE_MAX;
      end
      FUNC_READ: begin
        hist_d = '0;
        if (cnt_inc == CNT_LAST) begin
          emit   = 1'b1;
          kind_d = KIND_DISTANCE;
          avg_d  = avg_prod[AVG_SH +: RANGE_W];
          dmax_d = max_new;
          dmin_d = min_new;
          cnt_d  = '0;
          sum_d  = '0;
          max_d  = '0;
          min_d  = RANGE_MAX;
        end else begin
          cnt_d = cnt_inc;
          sum_d = sum_inc;
          max_d = max_new;
          min_d = min_new;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trigger_level_q <= RANGE_MAX;
      interval_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TRIGGER_LEVEL: trigger_level_q <= cfg_data_i[RANGE_W-1:0];
        CFG_INTERVAL:      interval_q      <= cfg_data_i;
        default:           interval_q      <= interval_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= 1'b0;
      hist_q      <= '0;
      notice_en_q <= 1'b1;
      cnt_q       <= '0;
      sum_q       <= '0;
      max_q       <= '0;
      min_q       <= RANGE_MAX;
      trig_q      <= RANGE_MAX;
    end else if (accept) begin
      armed_q     <= armed_d;
      hist_q      <= hist_d;
      notice_en_q <= notice_en_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      max_q       <= max_d;
      min_q       <= min_d;
      trig_q      <= trig_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      out_valid_q <= accept && emit;
    end
  end

  // result payload, loaded only with a new result
  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      kind_q   <= kind_d;
      avg_q    <= avg_d;
      dmax_q   <= dmax_d;
      dmin_q   <= dmin_d;
      period_q <= period_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign result_kind_o      = kind_q;
  assign distance_average_o = avg_q;
  assign distance_maximum_o = dmax_q;
  assign distance_minimum_o = dmin_q;
  assign sample_period_ms_o = period_q;

  a_hist_only_armed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !armed_q |-> (hist_q == '0))
    else $error("hit history nonzero while disarmed");

  a_block_only_armed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !notice_en_q |-> armed_q)
    else $error("notices blocked while disarmed");

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < CNT_LAST)
    else $error("read count reached group size without a report");

  a_notice_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && emit && (kind_d == KIND_OBSTACLE)) |=> !notice_en_q)
    else $error("obstacle notice did not block further notices");

  a_arm_reports : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(armed_q) |-> (out_valid_q && (kind_q == KIND_PERIOD)))
    else $error("turn-on without sample period report");

endmodule
